/* sv/kjb_pkg.sv */
package kjb_pkg;

  // Number of watched make codes, one key bit each
  localparam int unsigned WATCH_COUNT = 8;

  // Register file geometry: 64-bit registers at byte address 8*i
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned REG_LSB = 3;

  localparam logic [7:0] JOY0_HEADER_RESET = 8'hFE;
  localparam logic [7:0] JOY1_HEADER_RESET = 8'hFF;

  typedef enum logic [1:0] {
    REG_WATCH    = 2'd0,
    REG_JOY0_HDR = 2'd1,
    REG_JOY1_HDR = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_KEY    = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_JOY0   = 2'd2,
    KIND_JOY1   = 2'd3
  } byte_kind_t;

endpackage

/* sv/keyboard_joystick_byte_decoder.sv */
// Channel  | Handshake           | Word
// -------- | ------------------- | -----------------------------------------------
// input    | in_valid, in_stall  | rx_byte
// output   | out_valid, out_stall| key_state, last_scancode, joy0_state, joy1_state,
//          |                     | byte_kind
// config   | APB (psel/penable)  | watch_scancodes @0x00, joy0_header @0x08,
//          |                     | joy1_header @0x10
//
// One word per cycle sustained while the output is not stalled; an accepted word passes
// through the input register, then the decode into the result/state registers.
// The input register lets one more word in while a result is stalled on the output.
// Synchronous reset clears mode, key, scancode and joystick state, and sets the
// headers to 0xFE and 0xFF. No clearing pass is needed.
module keyboard_joystick_byte_decoder #(
  parameter int unsigned WATCH_COUNT = kjb_pkg::WATCH_COUNT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kjb_pkg::ADDR_W-1:0] paddr,
  input  logic [kjb_pkg::DATA_W-1:0] pwdata,
  output logic [kjb_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 rx_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 key_state,
  output logic [7:0]                 last_scancode,
  output logic [7:0]                 joy0_state,
  output logic [7:0]                 joy1_state,
  output logic [1:0]                 byte_kind
);

  localparam int unsigned WatchW = 8 * WATCH_COUNT;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_JOY0 = 2'd1,
    MODE_JOY1 = 2'd2
  } mode_t;

  // Configuration registers
  logic [WatchW-1:0] watch_scancodes;
  logic [7:0]        joy0_header;
  logic [7:0]        joy1_header;

  kjb_pkg::reg_index_t reg_sel;
  logic                cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = kjb_pkg::reg_index_t'(paddr[kjb_pkg::ADDR_W-1:kjb_pkg::REG_LSB]);
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      watch_scancodes <= '0;
      joy0_header     <= kjb_pkg::JOY0_HEADER_RESET;
      joy1_header     <= kjb_pkg::JOY1_HEADER_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        kjb_pkg::REG_WATCH:    watch_scancodes <= pwdata[WatchW-1:0];
        kjb_pkg::REG_JOY0_HDR: joy0_header     <= pwdata[7:0];
        kjb_pkg::REG_JOY1_HDR: joy1_header     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      kjb_pkg::REG_WATCH:    prdata = kjb_pkg::DATA_W'(watch_scancodes);
      kjb_pkg::REG_JOY0_HDR: prdata = kjb_pkg::DATA_W'(joy0_header);
      kjb_pkg::REG_JOY1_HDR: prdata = kjb_pkg::DATA_W'(joy1_header);
      default:               prdata = '0;
    endcase
  end

  // Input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       advance;

  assign advance  = s1_valid & ~(out_valid & out_stall);
  assign in_stall = s1_valid & ~advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (~in_stall) begin
      s1_valid <= in_valid;
    end
    if (in_valid & ~in_stall) begin
      s1_byte <= rx_byte;
    end
  end

  // Decode state, which is also the result word
  mode_t               mode, mode_next;
  logic [7:0]          held_keys, held_keys_next;
  logic [7:0]          raw_scancode, raw_scancode_next;
  logic [7:0]          stick0, stick0_next;
  logic [7:0]          stick1, stick1_next;
  kjb_pkg::byte_kind_t kind, kind_next;

  always_comb begin
    mode_next         = MODE_IDLE;
    held_keys_next    = held_keys;
    raw_scancode_next = raw_scancode;
    stick0_next       = stick0;
    stick1_next       = stick1;
    kind_next         = kjb_pkg::KIND_KEY;
    case (mode)
      MODE_JOY0: begin
        stick0_next = s1_byte;
        kind_next   = kjb_pkg::KIND_JOY0;
      end
      MODE_JOY1: begin
        stick1_next = s1_byte;
        kind_next   = kjb_pkg::KIND_JOY1;
      end
      default: begin
        if (s1_byte == joy0_header) begin
          mode_next = MODE_JOY0;
          kind_next = kjb_pkg::KIND_HEADER;
        end else if (s1_byte == joy1_header) begin
          mode_next = MODE_JOY1;
          kind_next = kjb_pkg::KIND_HEADER;
        end else begin
          raw_scancode_next = s1_byte;
          // Every matching entry moves its own bit; bit 7 set means break
          for (int i = 0; i < WATCH_COUNT; i++) begin
            if (watch_scancodes[8*i +: 8] == {1'b0, s1_byte[6:0]}) begin
              held_keys_next[i] = ~s1_byte[7];
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      held_keys    <= '0;
      raw_scancode <= '0;
      stick0       <= '0;
      stick1       <= '0;
      kind         <= kjb_pkg::KIND_KEY;
      out_valid    <= 1'b0;
    end else begin
      if (advance) begin
        mode         <= mode_next;
        held_keys    <= held_keys_next;
        raw_scancode <= raw_scancode_next;
        stick0       <= stick0_next;
        stick1       <= stick1_next;
        kind         <= kind_next;
        out_valid    <= 1'b1;
      end else if (~out_stall) begin
        out_valid    <= 1'b0;
      end
    end
  end

  assign key_state     = held_keys;
  assign last_scancode = raw_scancode;
  assign joy0_state    = stick0;
  assign joy1_state    = stick1;
  assign byte_kind     = kind;

endmodule

/* sv/kjb_checker.sv */
module kjb_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] key_state,
  input logic [7:0] last_scancode,
  input logic [1:0] byte_kind
);

  // Kind of the last word taken from the output
  logic       have_prev;
  logic [1:0] prev_kind;
  logic       out_take;

  assign out_take = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      prev_kind <= kjb_pkg::KIND_KEY;
    end else if (out_take) begin
      have_prev <= 1'b1;
      prev_kind <= byte_kind;
    end
  end

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(byte_kind) && $stable(key_state))
    else $error("stalled result word changed");

  // Joystick data only follows a header
  a_joy_after_hdr: assert property (@(posedge clk) disable iff (rst)
    out_valid && (byte_kind == kjb_pkg::KIND_JOY0 || byte_kind == kjb_pkg::KIND_JOY1)
    |-> have_prev && prev_kind == kjb_pkg::KIND_HEADER)
    else $error("joystick data without a preceding header");

  // A header is always followed by joystick data
  a_hdr_then_joy: assert property (@(posedge clk) disable iff (rst)
    out_valid && have_prev && prev_kind == kjb_pkg::KIND_HEADER
    |-> byte_kind == kjb_pkg::KIND_JOY0 || byte_kind == kjb_pkg::KIND_JOY1)
    else $error("header not followed by joystick data");

  // Joystick data leaves key state untouched
  a_joy_keeps_keys: assert property (@(posedge clk) disable iff (rst)
    out_take ##1 out_valid && (byte_kind == kjb_pkg::KIND_JOY0 ||
                               byte_kind == kjb_pkg::KIND_JOY1)
    |-> $stable(key_state) && $stable(last_scancode))
    else $error("joystick data moved key state");

  // Drop the result after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind keyboard_joystick_byte_decoder kjb_checker u_kjb_checker (.*);
